// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the matrix-vector multiply RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define MVM_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("mvm assertion failed");
// Condition must never be true outside reset.
`define MVM_ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("mvm forbidden condition seen");
`else
`define MVM_ASSERT(lbl, clk, rst, prop)
`define MVM_ASSERT_NEVER(lbl, clk, rst, cond)
`endif
`endif

// ----- rtl/mvm_pkg.sv -----
// Shared types and constants for the matrix-vector multiply block.
`default_nettype none
package mvm_pkg;

  localparam int MAX_COLS_DEF = 1024;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

  localparam int NUM_COLS_W = 11;
  localparam int NUM_ROWS_W = 16;
  localparam int CFG_DATA_W = 16;
  localparam int VAL_W      = 32;
  localparam int IDX_W      = 10;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_MATRIX = 1'b1;

  localparam logic REG_NUM_COLS = 1'b0;
  localparam logic REG_NUM_ROWS = 1'b1;

  localparam logic [NUM_COLS_W-1:0] NUM_COLS_RST = 11'd1024;
  localparam logic [NUM_ROWS_W-1:0] NUM_ROWS_RST = 16'd1024;

  // One matrix element with its vector operand and row bookkeeping.
  typedef struct packed {
    logic [VAL_W-1:0]      mat_val;
    logic [VAL_W-1:0]      vec_val;
    logic                  col_last;
    logic [NUM_ROWS_W-1:0] row_num;
    logic                  last_row;
  } mvm_op_t;

  typedef struct packed {
    logic    valid;
    mvm_op_t op;
  } mvm_push_t;

endpackage
`default_nettype wire

// ----- rtl/mvm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mvm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- rtl/mvm_front.sv -----
// Front end: config registers, item intake, vector store, row/column tracking.
`default_nettype none
`include "assert_macros.svh"
module mvm_front import mvm_pkg::*; #(
  parameter int MAX_COLS = MAX_COLS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic                  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  item_valid,
  output logic                       item_stall,
  input  wire logic                  cmd,
  input  wire logic [IDX_W-1:0]      vec_index,
  input  wire logic [VAL_W-1:0]      operand_value,
  input  wire logic                  almost_full,
  output mvm_push_t                  push
);

  localparam int ADDR_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int CNT_W  = ADDR_W + 1;

  logic [NUM_COLS_W-1:0] num_cols;
  logic [NUM_ROWS_W-1:0] num_rows;
  logic [ADDR_W-1:0]     col_pos;
  logic [NUM_ROWS_W-1:0] row_pos;

  logic                  s1_valid;
  logic [VAL_W-1:0]      s1_mat_val;
  logic                  s1_col_last;
  logic [NUM_ROWS_W-1:0] s1_row_num;
  logic                  s1_last_row;

  logic                  accept, acc_load, acc_mat;
  logic [31:0]           idx_ext;
  logic                  idx_ok;
  logic [CNT_W-1:0]      cols_eff, col_inc;
  logic [NUM_ROWS_W:0]   rows_eff, row_inc;
  logic                  col_last, row_last;
  logic [VAL_W-1:0]      vec_rdata;

  assign cfg_ready  = 1'b1;
  assign item_stall = almost_full;
  assign accept     = item_valid && !item_stall;
  assign acc_load   = accept && (cmd == CMD_LOAD);
  assign acc_mat    = accept && (cmd == CMD_MATRIX);

  assign idx_ext = 32'(vec_index);
  assign idx_ok  = idx_ext < 32'(MAX_COLS);

  always_comb begin
    if (num_cols == '0) begin
      cols_eff = CNT_W'(1);
    end else if (32'(num_cols) > 32'(MAX_COLS)) begin
      cols_eff = CNT_W'(MAX_COLS);
    end else begin
      cols_eff = CNT_W'(num_cols);
    end
    rows_eff = (num_rows == '0) ? (NUM_ROWS_W+1)'(1) : {1'b0, num_rows};
    col_inc  = {1'b0, col_pos} + CNT_W'(1);
    row_inc  = {1'b0, row_pos} + (NUM_ROWS_W+1)'(1);
    col_last = col_inc >= cols_eff;
    row_last = row_inc >= rows_eff;
  end

  mvm_ram #(
    .WIDTH (VAL_W),
    .DEPTH (MAX_COLS)
  ) u_store (
    .clk   (clk),
    .we    (acc_load && idx_ok),
    .waddr (idx_ext[ADDR_W-1:0]),
    .wdata (operand_value),
    .raddr (col_pos),
    .rdata (vec_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      num_cols <= NUM_COLS_RST;
      num_rows <= NUM_ROWS_RST;
      col_pos  <= '0;
      row_pos  <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_NUM_COLS: num_cols <= cfg_data[NUM_COLS_W-1:0];
          REG_NUM_ROWS: num_rows <= cfg_data[NUM_ROWS_W-1:0];
          default: ;
        endcase
      end
      s1_valid <= acc_mat;
      if (acc_mat) begin
        if (col_last) begin
          col_pos <= '0;
          row_pos <= row_last ? '0 : row_inc[NUM_ROWS_W-1:0];
        end else begin
          col_pos <= col_inc[ADDR_W-1:0];
        end
      end
    end
  end

  // Payload alongside the store read; no reset needed.
  always_ff @(posedge clk) begin
    if (acc_mat) begin
      s1_mat_val  <= operand_value;
      s1_col_last <= col_last;
      s1_row_num  <= row_pos;
      s1_last_row <= col_last && row_last;
    end
  end

  always_comb begin
    push.valid       = s1_valid;
    push.op.mat_val  = s1_mat_val;
    push.op.vec_val  = vec_rdata;
    push.op.col_last = s1_col_last;
    push.op.row_num  = s1_row_num;
    push.op.last_row = s1_last_row;
  end

  `MVM_ASSERT(a_col_in_range, clk, rst, 32'(col_pos) < 32'(MAX_COLS))
  `MVM_ASSERT(a_s1_follows_accept, clk, rst, s1_valid == ($past(acc_mat) && !$past(rst)))
  `MVM_ASSERT_NEVER(a_row_past_end, clk, rst, {1'b0, row_pos} >= rows_eff && s1_valid && s1_last_row)

endmodule
`default_nettype wire

// ----- rtl/mvm_queue.sv -----
// Short queue between front end and multiply-accumulate back end.
`default_nettype none
`include "assert_macros.svh"
module mvm_queue import mvm_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire mvm_push_t  push,
  output logic            almost_full,
  output logic            q_valid,
  output mvm_op_t         q_data,
  input  wire logic       pop
);

  mvm_op_t           slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_pop;

  assign q_valid     = count != '0;
  assign q_data      = slots[rd_ptr];
  assign do_pop      = pop && q_valid;
  // one slot kept spare for the item already in the store read stage
  assign almost_full = count >= QCNT_W'(QUEUE_DEPTH - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push.valid && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (!push.valid && do_pop) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      slots[wr_ptr] <= push.op;
    end
  end

  `MVM_ASSERT_NEVER(a_push_when_full, clk, rst, push.valid && count == QCNT_W'(QUEUE_DEPTH))
  `MVM_ASSERT(a_count_bound, clk, rst, count <= QCNT_W'(QUEUE_DEPTH))
  `MVM_ASSERT_NEVER(a_pop_when_empty, clk, rst, pop && !q_valid)

endmodule
`default_nettype wire

// ----- rtl/mvm_back.sv -----
// Back end: multiply stage, running sum and result output register.
`default_nettype none
`include "assert_macros.svh"
module mvm_back import mvm_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   q_valid,
  input  wire mvm_op_t                q_data,
  output logic                        pop,
  output logic                        result_valid,
  input  wire logic                   result_stall,
  output logic      [VAL_W-1:0]       row_sum,
  output logic      [NUM_ROWS_W-1:0]  row_number,
  output logic                        last_row
);

  logic                  a_valid;
  logic [VAL_W-1:0]      a_prod;
  logic                  a_col_last;
  logic [NUM_ROWS_W-1:0] a_row;
  logic                  a_last;
  logic [VAL_W-1:0]      acc;
  logic [VAL_W-1:0]      acc_next;
  logic                  b_take, a_advance, emit;

  assign b_take    = !(a_col_last && result_valid && result_stall);
  assign a_advance = !a_valid || b_take;
  assign pop       = q_valid && a_advance;
  assign emit      = a_valid && a_col_last && b_take;
  assign acc_next  = acc + a_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid      <= 1'b0;
      acc          <= '0;
      result_valid <= 1'b0;
    end else begin
      if (a_advance) begin
        a_valid <= pop;
      end
      if (a_valid && b_take) begin
        acc <= a_col_last ? '0 : acc_next;
      end
      if (emit) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // low 32 bits of the product are the same signed or unsigned
  always_ff @(posedge clk) begin
    if (pop) begin
      a_prod     <= VAL_W'(q_data.mat_val * q_data.vec_val);
      a_col_last <= q_data.col_last;
      a_row      <= q_data.row_num;
      a_last     <= q_data.last_row;
    end
    if (emit) begin
      row_sum    <= acc_next;
      row_number <= a_row;
      last_row   <= a_last;
    end
  end

  `MVM_ASSERT(a_held_stage_keeps, clk, rst, (a_valid && !a_advance) |=> a_valid && $stable(a_prod))
  `MVM_ASSERT(a_sum_cleared_after_row, clk, rst, emit |=> acc == '0)
  `MVM_ASSERT_NEVER(a_emit_over_pending, clk, rst, emit && result_valid && result_stall)

endmodule
`default_nettype wire

// ----- rtl/matrix_vector_multiply.sv -----
// Matrix-vector multiply: vector element loads, then streamed row-major matrix elements.
// Throughput: one item per cycle; item_stall rises only when a stalled result backs up the queue.
// A row's result is valid once its last element has passed the store read register,
//   the queue write, the multiply register and the sum into the output register.
// Synchronous reset clears config (1024 columns, 1024 rows), positions, sum and queue;
//   the vector store is not cleared and must be loaded before use.
`default_nettype none
module matrix_vector_multiply import mvm_pkg::*; #(
  parameter int MAX_COLS = MAX_COLS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic                  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  item_valid,
  output logic                       item_stall,
  input  wire logic                  cmd,
  input  wire logic [IDX_W-1:0]      vec_index,
  input  wire logic [VAL_W-1:0]      operand_value,
  output logic                       result_valid,
  input  wire logic                  result_stall,
  output logic      [VAL_W-1:0]      row_sum,
  output logic      [NUM_ROWS_W-1:0] row_number,
  output logic                       last_row
);

  mvm_push_t push;
  logic      almost_full;
  logic      q_valid;
  mvm_op_t   q_data;
  logic      pop;

  mvm_front #(
    .MAX_COLS (MAX_COLS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .cmd           (cmd),
    .vec_index     (vec_index),
    .operand_value (operand_value),
    .almost_full   (almost_full),
    .push          (push)
  );

  mvm_queue u_queue (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .almost_full (almost_full),
    .q_valid     (q_valid),
    .q_data      (q_data),
    .pop         (pop)
  );

  mvm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_data       (q_data),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .row_sum      (row_sum),
    .row_number   (row_number),
    .last_row     (last_row)
  );

endmodule
`default_nettype wire

// ----- bench/tb_matrix_vector_multiply.sv -----
// Self-checking testbench for the streamed integer matrix-vector multiply block.
module tb_matrix_vector_multiply;
  import mvm_pkg::*;

  localparam int MAXC         = MAX_COLS_DEF;
  localparam int SMALL_COLS   = 12;
  localparam int SMALL_TARGET = 1550;
  localparam int CALM_TAIL    = 200;   // last items of the run go without idling
  localparam int DRAIN_CYCLES = 6;
  localparam int QUIET_LIMIT  = 1000;

  typedef struct packed {
    logic                  kind;
    logic [IDX_W-1:0]      idx;
    logic [VAL_W-1:0]      val;
  } mvm_item_t;

  typedef struct packed {
    logic [VAL_W-1:0]      sum;
    logic [NUM_ROWS_W-1:0] row;
    logic                  last;
  } row_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic                  cfg_index = REG_NUM_COLS;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  item_valid = 1'b0;
  logic                  item_stall;
  logic                  cmd = CMD_LOAD;
  logic [IDX_W-1:0]      vec_index = '0;
  logic [VAL_W-1:0]      operand_value = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  logic [VAL_W-1:0]      row_sum;
  logic [NUM_ROWS_W-1:0] row_number;
  logic                  last_row;

  matrix_vector_multiply dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .item_valid(item_valid), .item_stall(item_stall),
    .cmd(cmd), .vec_index(vec_index), .operand_value(operand_value),
    .result_valid(result_valid), .result_stall(result_stall),
    .row_sum(row_sum), .row_number(row_number), .last_row(last_row)
  );

  always #5 clk = ~clk;

  // shadow copy of the block's state
  logic [VAL_W-1:0]      vec_shadow [MAXC];
  logic [VAL_W-1:0]      sum_shadow = '0;
  int unsigned           col_shadow = 0;
  logic [NUM_ROWS_W-1:0] row_shadow = '0;
  logic [NUM_COLS_W-1:0] cols_shadow = NUM_COLS_RST;
  logic [NUM_ROWS_W-1:0] rows_shadow = NUM_ROWS_RST;

  row_result_t row_sums_due [$];
  mvm_item_t   pending_items [$];
  logic        loaded [MAXC];
  int unsigned store_prefix = 0;   // entries below this index have all been written
  int          queued_items = 0;
  int          mismatches = 0;
  int          idle_pct = 0;
  int          gap_left = 0;
  int          stall_left = 0;
  int          quiet_cycles = 0;

  function automatic int unsigned eff_cols(input logic [NUM_COLS_W-1:0] c);
    if (c == 0) return 1;
    if (c > MAXC) return MAXC;
    return 32'(c);
  endfunction

  function automatic void predict_row_sum(input logic c, input logic [IDX_W-1:0] idx,
                                          input logic [VAL_W-1:0] v);
    int unsigned ncols;
    int unsigned nrows;
    row_result_t r;
    if (c == CMD_LOAD) begin
      vec_shadow[idx] = v;
      return;
    end
    ncols = eff_cols(cols_shadow);
    nrows = (rows_shadow == 0) ? 1 : 32'(rows_shadow);
    sum_shadow = sum_shadow + v * vec_shadow[col_shadow];
    if (col_shadow + 1 < ncols) begin
      col_shadow++;
      return;
    end
    r.sum  = sum_shadow;
    r.row  = row_shadow;
    r.last = (row_shadow + 1 >= nrows);
    row_sums_due.push_back(r);
    sum_shadow = '0;
    col_shadow = 0;
    row_shadow = r.last ? '0 : row_shadow + 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic logic [VAL_W-1:0] rand_operand();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0;
      default: return $urandom();
    endcase
  endfunction

  function automatic void push_load(input int unsigned idx, input logic [VAL_W-1:0] v);
    mvm_item_t it;
    it.kind = CMD_LOAD;
    it.idx  = IDX_W'(idx);
    it.val  = v;
    pending_items.push_back(it);
    loaded[idx] = 1'b1;
    while (store_prefix < MAXC && loaded[store_prefix]) store_prefix++;
    queued_items++;
  endfunction

  function automatic void push_element(input logic [VAL_W-1:0] v);
    mvm_item_t it;
    it.kind = CMD_MATRIX;
    it.idx  = IDX_W'($urandom());   // ignored by matrix items
    it.val  = v;
    pending_items.push_back(it);
    queued_items++;
  endfunction

  task automatic write_register(input logic idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_NUM_COLS) cols_shadow = data[NUM_COLS_W-1:0];
    else rows_shadow = data;
  endtask

  // all items accepted, all rows returned, then let the pipeline settle
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_items.size() != 0 || item_valid || row_sums_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    mvm_item_t nxt;
    if (rst) begin
      item_valid <= 1'b0;
      gap_left = 0;
    end else if (!item_valid || !item_stall) begin
      if (gap_left == 0 && idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        gap_left = $urandom_range(1, 6);
      if (gap_left > 0) begin
        gap_left--;
        item_valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        nxt = pending_items.pop_front();
        item_valid    <= 1'b1;
        cmd           <= nxt.kind;
        vec_index     <= nxt.idx;
        operand_value <= nxt.val;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // monitor: predicts from accepted items, checks accepted rows, stalls the output
  always @(posedge clk) begin
    row_result_t want;
    if (rst) begin
      result_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (item_valid && !item_stall) predict_row_sum(cmd, vec_index, operand_value);
      if (result_valid && !result_stall) begin
        if (row_sums_due.size() == 0) begin
          report_mismatch("row with nothing expected", row_sum, '0);
        end else begin
          want = row_sums_due.pop_front();
          if (row_sum !== want.sum) report_mismatch("row_sum", row_sum, want.sum);
          if (row_number !== want.row)
            report_mismatch("row_number", 32'(row_number), 32'(want.row));
          if (last_row !== want.last)
            report_mismatch("last_row", 32'(last_row), 32'(want.last));
        end
      end
      if (stall_left > 0) stall_left--;
      else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        stall_left = $urandom_range(1, 6);
      result_stall <= (stall_left > 0);
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    int          small_items;
    int unsigned ncols;
    int unsigned cmax;
    int unsigned c;
    int          nrows_gen;
    int          k;
    logic [NUM_ROWS_W-1:0] rdata;

    for (int i = 0; i < MAXC; i++) loaded[i] = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: operand extremes, overflow, both commands, top index
    write_register(REG_NUM_COLS, 16'd4);
    write_register(REG_NUM_ROWS, 16'd2);
    push_load(0, 32'h8000_0000);
    push_load(1, 32'h7FFF_FFFF);
    push_load(2, 32'hFFFF_FFFF);
    push_load(3, 32'h0);
    push_load(4, 32'h1);
    push_load(5, $urandom());
    push_load(MAXC - 1, $urandom());
    push_element(32'h8000_0000);
    push_element(32'h7FFF_FFFF);
    push_element(32'hFFFF_FFFF);
    push_element(32'h1234_5678);
    push_element(32'h7FFF_FFFF);
    push_element(32'h8000_0000);
    push_element(32'h8000_0000);
    push_element(32'h1);
    wait_idle();
    // zero columns act as one, zero rows make every row the last
    write_register(REG_NUM_COLS, 16'd0);
    write_register(REG_NUM_ROWS, 16'd0);
    push_element(32'h7FFF_FFFF);
    push_element(32'hFFFF_FFFF);
    wait_idle();
    // column count shrinks under a partial row: next element closes it
    write_register(REG_NUM_COLS, 16'd6);
    write_register(REG_NUM_ROWS, 16'd3);
    push_element($urandom());
    push_element($urandom());
    push_element($urandom());
    wait_idle();
    write_register(REG_NUM_COLS, 16'd2);
    push_element($urandom());

    small_items = queued_items;
    while (small_items < SMALL_TARGET) begin
      wait_idle();
      if (small_items >= SMALL_TARGET - CALM_TAIL) idle_pct = 0;
      else case ($urandom_range(0, 2))
        0: idle_pct = 0;
        1: idle_pct = 10;
        default: idle_pct = 35;
      endcase

      if ($urandom_range(0, 3) != 0) begin
        cmax = (store_prefix < SMALL_COLS) ? store_prefix : SMALL_COLS;
        case ($urandom_range(0, 9))
          0: c = 0;
          1: c = 1;
          default: c = $urandom_range(1, cmax);
        endcase
        write_register(REG_NUM_COLS, {5'($urandom()), NUM_COLS_W'(c)});
      end
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 4))
          0: rdata = '0;
          1: rdata = 16'd1;
          2: rdata = 16'hFFFF;
          3: rdata = NUM_ROWS_W'($urandom_range(2, 5));
          default: rdata = NUM_ROWS_W'($urandom());
        endcase
        write_register(REG_NUM_ROWS, rdata);
      end

      // grow the written part of the store a little
      if (store_prefix < SMALL_COLS && $urandom_range(0, 1) == 1) begin
        k = $urandom_range(1, 3);
        for (int i = 0; i < k && store_prefix < MAXC; i++)
          push_load(store_prefix, rand_operand());
      end

      ncols = eff_cols(cols_shadow);
      nrows_gen = $urandom_range(1, 5);
      for (int r = 0; r < nrows_gen; r++) begin
        for (int e = 0; e < ncols; e++) begin
          // stray loads mid-row, anywhere in the store
          if ($urandom_range(0, 9) == 0) push_load($urandom_range(0, MAXC - 1), rand_operand());
          push_element(rand_operand());
        end
      end
      // broken row: leaves a partial sum for the next setting to pick up
      if ($urandom_range(0, 4) == 0) begin
        k = $urandom_range(1, 2 * ncols);
        for (int i = 0; i < k; i++) push_element(rand_operand());
      end
      small_items = queued_items;
    end

    // final drain: wait until every item is taken and every row has come out
    wait_idle();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
